>>> src/pot_pkg.sv
// Package: shared types and constants for the packed offset table decoder.
`timescale 1ns / 1ps

package pot_pkg;

  // Width of the running address accumulator (32 to 64).
  localparam int unsigned AddrWidth = 32;

  localparam int unsigned ValueWidth = 30;

  // Result status codes.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEnd   = 2'd1;
  localparam logic [1:0] StError = 2'd2;

  // Entry size prefixes (top two bits of the first byte).
  localparam logic [1:0] PfxOneByte  = 2'b01;
  localparam logic [1:0] PfxTwoByte  = 2'b10;
  localparam logic [1:0] PfxFourByte = 2'b11;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       last_byte;
  } pot_in_t;

  typedef struct packed {
    logic [31:0] pointer_address;
    logic [1:0]  status;
    logic        table_end;
  } pot_out_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  running_address;
    logic [ValueWidth-1:0] partial_value;
    logic [1:0]            bytes_pending;
    logic                  draining;
  } pot_state_t;

endpackage

>>> src/pot_step.sv
// Combinational per-byte decode: next decoder state and optional result.
`timescale 1ns / 1ps

module pot_step import pot_pkg::*; (
  input  pot_state_t  state_i,
  input  logic [31:0] base_i,
  input  pot_in_t     in_i,
  output pot_state_t  next_o,
  output logic        res_valid_o,
  output pot_out_t    res_o
);

  pot_state_t            rearm;
  logic [ValueWidth-1:0] gathered;
  logic [ValueWidth-1:0] value;
  logic [AddrWidth-1:0]  sum;
  logic [7:0]            b;
  logic                  last;

  assign b    = in_i.table_byte;
  assign last = in_i.last_byte;

  always_comb begin
    rearm.running_address = AddrWidth'(base_i);
    rearm.partial_value   = '0;
    rearm.bytes_pending   = 2'd0;
    rearm.draining        = 1'b0;
  end

  assign gathered = {state_i.partial_value[ValueWidth-9:0], b};
  assign value    = (state_i.bytes_pending != 2'd0) ? gathered
                                                    : ValueWidth'(b[5:0]);
  // offset is counted in words: value * 4
  assign sum = state_i.running_address + AddrWidth'({value, 2'b00});

  always_comb begin
    next_o      = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (state_i.draining) begin
      if (last) begin
        next_o = rearm;
      end
    end else if (state_i.bytes_pending != 2'd0) begin
      next_o.partial_value = gathered;
      next_o.bytes_pending = state_i.bytes_pending - 2'd1;
      if (state_i.bytes_pending == 2'd1) begin
        res_valid_o           = 1'b1;
        res_o.pointer_address = sum[31:0];
        res_o.status          = StOk;
        res_o.table_end       = last;
        next_o.running_address = sum;
        next_o.partial_value   = '0;
        if (last) begin
          next_o = rearm;
        end
      end else if (last) begin
        // table ran out mid-entry
        res_valid_o     = 1'b1;
        res_o.status    = StError;
        res_o.table_end = 1'b1;
        next_o          = rearm;
      end
    end else if (b == 8'h00) begin
      res_valid_o     = 1'b1;
      res_o.status    = StEnd;
      res_o.table_end = 1'b1;
      if (last) begin
        next_o = rearm;
      end else begin
        next_o.partial_value = '0;
        next_o.bytes_pending = 2'd0;
        next_o.draining      = 1'b1;
      end
    end else begin
      case (b[7:6])
        PfxOneByte: begin
          res_valid_o            = 1'b1;
          res_o.pointer_address  = sum[31:0];
          res_o.status           = StOk;
          res_o.table_end        = last;
          next_o.running_address = sum;
          if (last) begin
            next_o = rearm;
          end
        end
        PfxTwoByte, PfxFourByte: begin
          if (last) begin
            res_valid_o     = 1'b1;
            res_o.status    = StError;
            res_o.table_end = 1'b1;
            next_o          = rearm;
          end else begin
            next_o.partial_value = ValueWidth'(b[5:0]);
            next_o.bytes_pending = (b[7:6] == PfxTwoByte) ? 2'd1 : 2'd3;
          end
        end
        default: begin
          res_valid_o     = 1'b1;
          res_o.status    = StError;
          res_o.table_end = 1'b1;
          if (last) begin
            next_o = rearm;
          end else begin
            next_o.partial_value = '0;
            next_o.bytes_pending = 2'd0;
            next_o.draining      = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

>>> src/packed_offset_table_decoder_top.sv
// Top level: packed offset table decoder with state and result registers.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / in_data_i) carries one table
//    byte per beat plus a last flag marking the final byte of the table.
//  - Output channel (out_valid_o / out_ready_i / out_data_o) carries at most
//    one result per input beat: a decoded address (status 0), a zero-byte
//    terminator (status 1) or an invalid or truncated entry (status 2).
//  - Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the base
//    address; it also reloads the running address. Always ready. Write it
//    only while the decoder is idle.
//  - A result appears on the output in the cycle after the beat that
//    finishes an entry. The input takes one byte per cycle unless the
//    output stalls, set by the single decode pass before the result register.
//  - Multi-byte entries produce no result on their leading bytes.
//  - After a terminator or error, bytes are dropped up to the last-flagged
//    byte, then the decoder re-arms from the base address.
//  - Receiver stall: the result register holds its beat; input stays ready
//    as long as the result register is empty or is being drained this cycle.
//  - Reset clears the base address to 0 and re-arms the decoder.
`timescale 1ns / 1ps

module packed_offset_table_decoder_top import pot_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pot_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pot_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] base_q;
  pot_state_t  state_q, state_d, step_next;
  logic        step_res_valid;
  pot_out_t    step_res;
  logic        out_valid_q, out_valid_d;
  pot_out_t    out_q, out_d;
  logic        in_fire, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;

  pot_step u_step (
    .state_i     (state_q),
    .base_i      (base_q),
    .in_i        (in_data_i),
    .next_o      (step_next),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  // State update; a config write reloads the accumulator.
  always_comb begin
    state_d = in_fire ? step_next : state_q;
    if (cfg_fire) begin
      state_d.running_address = AddrWidth'(cfg_data_i);
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && step_res_valid) begin
      out_valid_d = 1'b1;
      out_d       = step_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        base_q <= cfg_data_i;
      end
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Draining and a partly gathered entry never coexist.
  a_drain_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.draining |-> state_q.bytes_pending == 2'd0)
    else $error("draining with bytes pending");

  // End and error results carry a zero address.
  a_status_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StOk) |-> out_data_o.pointer_address == 32'd0)
    else $error("non-ok result with nonzero address");

  // A last-flagged byte always leaves the decoder re-armed.
  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_byte) |=>
      (state_q.bytes_pending == 2'd0 && !state_q.draining))
    else $error("decoder not re-armed after last byte");

  // A base write reloads the accumulator.
  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> state_q.running_address == AddrWidth'(base_q))
    else $error("running address not reloaded by base write");

endmodule
